>>> rtl/lcdst_pkg.sv
// Shared types and constants for the LCD scanline timing controller.
// No dependencies; imported by the top level and its checker.
package lcdst_pkg;

   localparam int unsigned DotsPerLine   = 456;
   localparam int unsigned LinesPerFrame = 154;
   localparam int unsigned VblankLine    = 144;
   localparam int unsigned ScanEnd       = 80;
   localparam int unsigned DrawEnd       = 252;
   localparam int unsigned WindowLeftMax = 166;

   localparam int unsigned CtrlEnableBit = 7;
   localparam int unsigned CtrlWindowBit = 5;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_SCAN   = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LCD_CONTROL  = 3'd0,
      CSR_STAT_ENABLES = 3'd1,
      CSR_COMPARE_LINE = 3'd2,
      CSR_WINDOW_TOP   = 3'd3,
      CSR_WINDOW_LEFT  = 3'd4
   } csr_index_type;

endpackage

>>> rtl/lcd_scanline_timing_controller.sv
// LCD scanline timing controller: dot/line counters, mode, interrupts, window line.
// Depends on lcdst_pkg.
//
// Usage:
//   req_ channel: one beat per tick, carrying the dots elapsed since the last tick.
//   rsp_ channel: one beat per tick: interrupts, line, mode, compare match, render
//                 strobe, window flag after that tick; window row before its render.
//   csr_ channel: register writes (index 0..4), always ready; indexes 5..7 are
//                 dropped. Write only while no beat is in flight.
// Path: a request beat lands in the input register at its accepting edge and
//   moves into the response register once that register is empty or being
//   read; rsp_valid then rises and the response beat waits for rsp_ready.
// Throughput: one beat per cycle while rsp_ready stays high. The timing update is
//   one pass of short logic (a 10-bit add, a compare against the line length,
//   a few compares), input register and timing state into the response register.
// Stall: with the response register full and stalled, the input register still
//   takes one more beat; req_ready falls only when both are occupied.
// Reset: synchronous, active high; clears all timing state, the config registers
//   and both valid flags.
module lcd_scanline_timing_controller (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_elapsed_dots,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_vblank_irq,
   output logic       rsp_stat_irq,
   output logic [7:0] rsp_current_line,
   output logic [1:0] rsp_current_mode,
   output logic       rsp_line_match,
   output logic       rsp_render_now,
   output logic [7:0] rsp_window_row,
   output logic       rsp_window_on,
   // configuration channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);
   import lcdst_pkg::*;

   // ---------------- configuration registers ----------------
   logic [7:0] lcd_control_ff, compare_line_ff, window_top_ff, window_left_ff;
   logic [3:0] stat_enables_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_control_ff  <= '0;
         stat_enables_ff <= '0;
         compare_line_ff <= '0;
         window_top_ff   <= '0;
         window_left_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LCD_CONTROL:  lcd_control_ff  <= csr_data;
            CSR_STAT_ENABLES: stat_enables_ff <= csr_data[3:0];
            CSR_COMPARE_LINE: compare_line_ff <= csr_data;
            CSR_WINDOW_TOP:   window_top_ff   <= csr_data;
            CSR_WINDOW_LEFT:  window_left_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic       in_valid_ff;
   logic [7:0] in_dots_ff;
   logic       out_load;

   assign out_load  = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_dots_ff <= req_elapsed_dots;
      end
   end

   // ---------------- timing state ----------------
   logic [8:0] dot_count_ff,   dot_count_in;
   logic [7:0] line_count_ff,  line_count_in;
   mode_type   mode_ff,        mode_in;
   logic [7:0] win_line_ff,    win_line_in;
   logic       win_flag_ff,    win_flag_in;
   logic       stat_level_ff,  stat_level_in;

   // result fields
   logic       vblank_in, stat_in, match_in, render_in;
   logic [7:0] row_in;

   // working values
   logic       enable;
   logic [9:0] dot_sum;
   logic       line_wrap;
   logic [8:0] dot_next;
   logic [7:0] line_inc;
   logic [7:0] win_line_mid;
   logic       win_flag_mid;
   logic       level;

   assign enable  = lcd_control_ff[CtrlEnableBit];
   assign dot_sum = {1'b0, dot_count_ff} + {2'b00, in_dots_ff};
   // the sum stays below two line lengths, so one subtract is enough
   assign line_wrap = (dot_sum >= 10'(DotsPerLine));
   assign dot_next  = line_wrap ? 9'(dot_sum - 10'(DotsPerLine)) : dot_sum[8:0];
   assign line_inc  = line_count_ff + 8'd1;

   always_comb begin
      dot_count_in  = dot_next;
      line_count_in = line_count_ff;
      win_line_mid  = win_line_ff;
      win_flag_mid  = win_flag_ff;
      vblank_in     = 1'b0;

      if (line_wrap) begin
         if (line_inc == 8'(LinesPerFrame)) begin
            // end of frame: window restarts
            line_count_in = '0;
            win_line_mid  = '0;
            win_flag_mid  = 1'b0;
         end else begin
            line_count_in = line_inc;
            vblank_in     = (line_inc == 8'(VblankLine));
         end
      end

      if (line_count_in >= 8'(VblankLine))      mode_in = MODE_VBLANK;
      else if (dot_count_in < 9'(ScanEnd))      mode_in = MODE_SCAN;
      else if (dot_count_in < 9'(DrawEnd))      mode_in = MODE_DRAW;
      else                                      mode_in = MODE_HBLANK;

      match_in  = (line_count_in == compare_line_ff);
      render_in = (mode_ff == MODE_DRAW) && (mode_in == MODE_HBLANK);
      row_in    = win_line_mid;

      win_flag_in = win_flag_mid;
      win_line_in = win_line_mid;
      if (render_in) begin
         if (line_count_in == window_top_ff) win_flag_in = 1'b1;
         if (win_flag_in && lcd_control_ff[CtrlWindowBit]
             && (window_left_ff <= 8'(WindowLeftMax))) begin
            win_line_in = win_line_mid + 8'd1;
         end
      end

      level = (stat_enables_ff[0] && (mode_in == MODE_HBLANK))
           || (stat_enables_ff[1] && (mode_in == MODE_VBLANK))
           || (stat_enables_ff[2] && (mode_in == MODE_SCAN))
           || (stat_enables_ff[3] && match_in);
      stat_in       = !stat_level_ff && level;
      stat_level_in = level;

      if (!enable) begin
         // display off: counters cleared, all fields zero, status level kept
         dot_count_in  = '0;
         line_count_in = '0;
         mode_in       = MODE_HBLANK;
         win_line_in   = '0;
         win_flag_in   = 1'b0;
         stat_level_in = stat_level_ff;
         vblank_in     = 1'b0;
         stat_in       = 1'b0;
         match_in      = 1'b0;
         render_in     = 1'b0;
         row_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_count_ff  <= '0;
         line_count_ff <= '0;
         mode_ff       <= MODE_HBLANK;
         win_line_ff   <= '0;
         win_flag_ff   <= 1'b0;
         stat_level_ff <= 1'b0;
      end else if (out_load) begin
         dot_count_ff  <= dot_count_in;
         line_count_ff <= line_count_in;
         mode_ff       <= mode_in;
         win_line_ff   <= win_line_in;
         win_flag_ff   <= win_flag_in;
         stat_level_ff <= stat_level_in;
      end
   end

   // ---------------- response register ----------------
   logic       rsp_valid_ff;
   logic       rsp_vblank_ff, rsp_stat_ff, rsp_match_ff, rsp_render_ff, rsp_win_on_ff;
   logic [7:0] rsp_line_ff, rsp_row_ff;
   mode_type   rsp_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_vblank_ff <= vblank_in;
         rsp_stat_ff   <= stat_in;
         rsp_line_ff   <= line_count_in;
         rsp_mode_ff   <= mode_in;
         rsp_match_ff  <= match_in;
         rsp_render_ff <= render_in;
         rsp_row_ff    <= row_in;
         rsp_win_on_ff <= win_flag_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vblank_irq   = rsp_vblank_ff;
   assign rsp_stat_irq     = rsp_stat_ff;
   assign rsp_current_line = rsp_line_ff;
   assign rsp_current_mode = rsp_mode_ff;
   assign rsp_line_match   = rsp_match_ff;
   assign rsp_render_now   = rsp_render_ff;
   assign rsp_window_row   = rsp_row_ff;
   assign rsp_window_on    = rsp_win_on_ff;

endmodule

>>> rtl/lcdst_checker.sv
// Port-level checker for the LCD scanline timing controller, bound to the top level.
// Depends on lcdst_pkg and lcd_scanline_timing_controller.
module lcdst_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_vblank_irq,
   input logic [7:0] rsp_current_line,
   input logic [1:0] rsp_current_mode,
   input logic       rsp_render_now
);
   import lcdst_pkg::*;

   // a stalled beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_current_line < 8'(LinesPerFrame)))
      else $error("line out of range");

   // vblank mode exactly on the vblank lines
   a_mode_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_current_line >= 8'(VblankLine)) == (rsp_current_mode == MODE_VBLANK)))
      else $error("mode disagrees with line");

   a_vblank_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_irq |-> (rsp_current_line == 8'(VblankLine)))
      else $error("vblank interrupt off line 144");

   a_render_hblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_render_now |-> (rsp_current_mode == MODE_HBLANK))
      else $error("render strobe outside hblank");

endmodule

bind lcd_scanline_timing_controller lcdst_checker u_lcdst_checker (.*);

>>> tb/tb_lcd_scanline_timing_controller.sv
`timescale 1ns / 100ps
// Self-checking testbench for lcd_scanline_timing_controller: directed display-off,
// line walk, window and CSR corner cases, then randomized ticks with and without idling.
// Depends on lcdst_pkg and the controller RTL.
module tb_lcd_scanline_timing_controller;
   import lcdst_pkg::*;

   localparam int CycleLimit      = 500000;
   localparam int DrainCycles     = 4;     // lets the input and response registers empty
   localparam int RandomPhases    = 12;
   localparam int TicksPerPhase   = 112;
   // CSR indexes past the last register; the block drops writes to these
   localparam int CsrUnusedFirst  = 5;
   localparam int CsrUnusedLast   = 7;

   // one response beat as the predictor sees it
   typedef struct packed {
      logic       vblank_irq;
      logic       stat_irq;
      logic [7:0] current_line;
      mode_type   current_mode;
      logic       line_match;
      logic       render_now;
      logic [7:0] window_row;
      logic       window_on;
   } timing_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_elapsed_dots = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_vblank_irq;
   logic       rsp_stat_irq;
   logic [7:0] rsp_current_line;
   logic [1:0] rsp_current_mode;
   logic       rsp_line_match;
   logic       rsp_render_now;
   logic [7:0] rsp_window_row;
   logic       rsp_window_on;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   lcd_scanline_timing_controller DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_elapsed_dots (req_elapsed_dots),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vblank_irq   (rsp_vblank_irq),
      .rsp_stat_irq     (rsp_stat_irq),
      .rsp_current_line (rsp_current_line),
      .rsp_current_mode (rsp_current_mode),
      .rsp_line_match   (rsp_line_match),
      .rsp_render_now   (rsp_render_now),
      .rsp_window_row   (rsp_window_row),
      .rsp_window_on    (rsp_window_on),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Timing predictor: shadow copy of the registers and the timing state.
   // Updated at the edge where a request beat or a CSR write is accepted.
   // ---------------------------------------------------------------------
   logic [7:0] lcd_ctrl   = '0;
   logic [3:0] stat_en    = '0;
   logic [7:0] cmp_line   = '0;
   logic [7:0] win_top    = '0;
   logic [7:0] win_left   = '0;

   logic [8:0] dot_cnt    = '0;
   logic [7:0] line_cnt   = '0;
   mode_type   mode_q     = MODE_HBLANK;
   logic [7:0] win_line   = '0;
   logic       win_flag   = 1'b0;
   logic       stat_level = 1'b0;

   timing_result_type expected_timing[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             burst_mode = 1'b0;   // both sides run without idling

   function automatic void apply_csr(input logic [2:0] idx, input logic [7:0] data);
      case (csr_index_type'(idx))
         CSR_LCD_CONTROL:  lcd_ctrl = data;
         CSR_STAT_ENABLES: stat_en  = data[3:0];
         CSR_COMPARE_LINE: cmp_line = data;
         CSR_WINDOW_TOP:   win_top  = data;
         CSR_WINDOW_LEFT:  win_left = data;
         default: ;
      endcase
   endfunction

   function automatic timing_result_type advance_timing(input logic [7:0] dots);
      timing_result_type r;
      logic [9:0]     sum;
      mode_type       prev_mode;
      mode_type       next_mode;
      logic           level;
      r = '0;
      // display off: counters and window state clear, status level holds
      if (!lcd_ctrl[CtrlEnableBit]) begin
         dot_cnt  = '0;
         line_cnt = '0;
         mode_q   = MODE_HBLANK;
         win_line = '0;
         win_flag = 1'b0;
         return r;
      end
      prev_mode = mode_q;
      // at most one line advance: 455 + 255 < 2 * 456
      sum = {1'b0, dot_cnt} + {2'b00, dots};
      if (sum >= DotsPerLine) begin
         sum      = sum - 10'(DotsPerLine);
         line_cnt = line_cnt + 8'd1;
         if (line_cnt == LinesPerFrame) begin
            line_cnt = '0;
            win_line = '0;
            win_flag = 1'b0;
         end else if (line_cnt == VblankLine) begin
            r.vblank_irq = 1'b1;
         end
      end
      dot_cnt = sum[8:0];

      if (line_cnt >= VblankLine)   next_mode = MODE_VBLANK;
      else if (dot_cnt < ScanEnd)   next_mode = MODE_SCAN;
      else if (dot_cnt < DrawEnd)   next_mode = MODE_DRAW;
      else                          next_mode = MODE_HBLANK;
      mode_q = next_mode;

      r.line_match = (line_cnt == cmp_line);
      // row reported is the count before any increment from this render
      r.window_row = win_line;
      if (prev_mode == MODE_DRAW && next_mode == MODE_HBLANK) begin
         r.render_now = 1'b1;
         if (line_cnt == win_top) win_flag = 1'b1;
         if (win_flag && lcd_ctrl[CtrlWindowBit] && win_left <= WindowLeftMax)
            win_line = win_line + 8'd1;
      end

      // drawing never feeds the status line
      level = (stat_en[0] && next_mode == MODE_HBLANK) ||
              (stat_en[1] && next_mode == MODE_VBLANK) ||
              (stat_en[2] && next_mode == MODE_SCAN)   ||
              (stat_en[3] && r.line_match);
      r.stat_irq     = !stat_level && level;
      stat_level     = level;
      r.current_line = line_cnt;
      r.current_mode = next_mode;
      r.window_on    = win_flag;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Idling and stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int draw_wait();
      return burst_mode ? 0 : $urandom_range(0, 14);
   endfunction

   // mostly large steps so frames wrap often, some small ones to land in
   // every mode window
   function automatic logic [7:0] draw_dots();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12)      return 8'($urandom_range(200, 255));
      else if (pick < 17) return 8'($urandom_range(0, 255));
      else                return 8'($urandom_range(0, 15));
   endfunction

   // one tick beat; valid stays up into the next call when no gap is drawn
   task automatic send_tick(input logic [7:0] dots);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_elapsed_dots <= dots;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_timing.insert(expected_timing.size(), advance_timing(dots));
   endtask

   // drop valid, let every response drain, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_timing.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic program_csr(input logic [2:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic apply_settings(input logic [7:0] ctrl, input logic [3:0] enables,
                                 input logic [7:0] cmp, input logic [7:0] top,
                                 input logic [7:0] left);
      wait_idle();
      program_csr(CSR_LCD_CONTROL, ctrl);
      program_csr(CSR_STAT_ENABLES, {4'h0, enables});
      program_csr(CSR_COMPARE_LINE, cmp);
      program_csr(CSR_WINDOW_TOP, top);
      program_csr(CSR_WINDOW_LEFT, left);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // control resets to zero, so ticks must come back all zero
   task automatic test_display_off_after_reset();
      send_tick(8'd0);
      send_tick(8'd255);
   endtask

   // walk line 0..2 through scan, draw and hblank edges with all status
   // sources on; window triggers on line 0 and counts on each render
   task automatic test_line_walk();
      apply_settings(8'hA0, 4'hF, 8'd1, 8'd0, 8'd7);
      send_tick(8'd0);     // dot 0, scan
      send_tick(8'd79);    // last scan dot
      send_tick(8'd1);     // first draw dot, status drops
      send_tick(8'd171);   // last draw dot
      send_tick(8'd1);     // hblank, render, window triggers
      send_tick(8'd203);   // last dot of line
      send_tick(8'd1);     // line 1, compare match
      send_tick(8'd80);    // draw
      send_tick(8'd255);   // hblank, render
      send_tick(8'd255);   // wrap straight into draw on line 2
      send_tick(8'd255);   // render again
   endtask

   // window left position one past the limit, then at the limit
   task automatic test_window_left_limit();
      apply_settings(8'hA0, 4'h1, 8'd3, 8'd0, 8'd167);
      send_tick(8'd255);   // line 3 draw
      send_tick(8'd100);   // render, counter holds
      apply_settings(8'hA0, 4'h1, 8'd3, 8'd0, 8'd166);
      send_tick(8'd255);   // line 4 draw
      send_tick(8'd200);   // render, counter advances
   endtask

   // disabling mid-frame clears the counters
   task automatic test_display_disable();
      apply_settings(8'h00, 4'hF, 8'd0, 8'd0, 8'd0);
      send_tick(8'd255);
      send_tick(8'd0);
   endtask

   // writes past the register map must leave the settings untouched
   task automatic test_unused_csr_index();
      apply_settings(8'h80, 4'h6, 8'd0, 8'd0, 8'd0);
      @(posedge clock);
      for (int i = CsrUnusedFirst; i <= CsrUnusedLast; i++)
         program_csr(3'(i), 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
      send_tick(8'd90);
      send_tick(8'd170);
   endtask

   // fixed extremes first, then random settings; every third phase runs
   // with no idling on either side
   task automatic test_random_phases();
      logic [7:0] ctrl;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: apply_settings(8'hFF, 4'hF, 8'd0,   8'd0,   8'd0);
            1: apply_settings(8'h80, 4'h0, 8'd255, 8'd255, 8'd255);
            2: apply_settings(8'hA0, 4'h8, 8'd153, 8'd143, 8'd166);
            3: apply_settings(8'h7F, 4'h1, 8'd144, 8'd1,   8'd167);
            default: begin
               ctrl = 8'($urandom_range(0, 255));
               ctrl[CtrlEnableBit] = ($urandom_range(0, 99) < 85);
               apply_settings(ctrl, 4'($urandom_range(0, 15)),
                              8'($urandom_range(0, 159)),
                              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 143)),
                              8'($urandom_range(0, 255)));
            end
         endcase
         burst_mode = (phase % 3 == 1);
         repeat (TicksPerPhase) send_tick(draw_dots());
      end
      burst_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure drawn per accepted beat
   // ---------------------------------------------------------------------
   int rsp_hold = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= (rsp_hold == 0);
      end else if (rsp_valid && rsp_ready) begin
         rsp_hold = draw_wait();
         rsp_ready <= (rsp_hold == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // compare each response beat against the oldest prediction
   always @(posedge clock) begin
      timing_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_timing.size() == 0) begin
            $error("response beat with no tick outstanding");
            mismatch_count++;
         end else begin
            want = expected_timing.pop_front();
            check_field("vblank_irq",   want.vblank_irq,   rsp_vblank_irq);
            check_field("stat_irq",     want.stat_irq,     rsp_stat_irq);
            check_field("current_line", want.current_line, rsp_current_line);
            check_field("current_mode", want.current_mode, rsp_current_mode);
            check_field("line_match",   want.line_match,   rsp_line_match);
            check_field("render_now",   want.render_now,   rsp_render_now);
            check_field("window_row",   want.window_row,   rsp_window_row);
            check_field("window_on",    want.window_on,    rsp_window_on);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_display_off_after_reset();
      test_line_walk();
      test_window_left_limit();
      test_display_disable();
      test_unused_csr_index();
      test_random_phases();

      // leftover predictions would still be queued here
      wait_idle();
      if (mismatch_count == 0 && expected_timing.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
